[rtl/core/lbcm_pkg.sv]
package lbcm_pkg;

  // Field widths of one request and one result.
  localparam int unsigned ValW   = 32;
  localparam int unsigned CodeW  = 8;
  localparam int unsigned ExtraW = 28;
  localparam int unsigned BitsW  = 5;
  localparam int unsigned GrpW   = 5;

  // Stream beat widths; both tdata widths are whole bytes (output tdata padded), tuser widths are not.
  localparam int unsigned InDataW  = 136;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 152;
  localparam int unsigned OutUserW = 1;

  // Bucket layout: values below eight are their own code, then eight buckets per group.
  localparam logic [CodeW-1:0] RsvCodes  = 8'd8;
  localparam logic [CodeW-1:0] LastCode  = 8'd231;
  localparam logic [ValW-1:0]  LastValue = 32'hFFFF_FFF7;
  localparam int unsigned      SlotW     = 3;

  // Lane numbers.
  localparam int unsigned LaneDist = 0;
  localparam int unsigned LaneLen  = 1;
  localparam int unsigned NumLanes = 2;

  // First stage, one lane: classified request.
  typedef struct packed {
    logic             dec;
    logic             act;
    logic             rsv;
    logic             err;
    logic [CodeW-1:0] code;
    logic [ValW-1:0]  val;
  } lbcm_s1_t;

  // Second stage, one lane: group number and decode base.
  typedef struct packed {
    logic             dec;
    logic             act;
    logic             rsv;
    logic             err;
    logic [CodeW-1:0] code;
    logic [GrpW-1:0]  grp;
    logic [ValW-1:0]  val;
    logic [ValW-1:0]  base;
  } lbcm_s2_t;

  // Output stage, one lane: result fields.
  typedef struct packed {
    logic              err;
    logic [CodeW-1:0]  code;
    logic [BitsW-1:0]  bits;
    logic [ExtraW-1:0] extra;
    logic [ValW-1:0]   value;
  } lbcm_res_t;

endpackage

[rtl/core/log_bucket_code_mapper.sv]
// Throughput: one beat per cycle unless the output stalls; the three stages advance
// independently, so a stalled output only holds the stages that are full behind it.
// Stage work: range check and extra mask, leading-one search and decode base,
// then slot/extra shift and the decode add.
// Reset clears the stage valid bits; payload registers are not reset.
module log_bucket_code_mapper (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // distance, length, dist_code_in, len_code_in, dist_extra_in, len_extra_in
  input  logic [lbcm_pkg::InDataW-1:0]   s_axis_tdata,
  // req_type, is_literal
  input  logic [lbcm_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // dist_code, len_code, dist_extra_bits, len_extra_bits, dist_extra, len_extra,
  // distance_out, length_out, zero padding
  output logic [lbcm_pkg::OutDataW-1:0]  m_axis_tdata,
  // error
  output logic [lbcm_pkg::OutUserW-1:0]  m_axis_tuser
);
  import lbcm_pkg::*;

  // Position of the highest set bit.
  function automatic logic [GrpW-1:0] msb_pos(input logic [ValW-1:0] v);
    logic [GrpW-1:0] p;
    p = '0;
    for (int b = 0; b < ValW; b++) begin
      if (v[b]) begin
        p = GrpW'(b);
      end
    end
    return p;
  endfunction

  logic [2:0] vld_q;
  logic [2:0] adv;

  lbcm_s1_t  s1_d [NumLanes];
  lbcm_s1_t  s1_q [NumLanes];
  lbcm_s2_t  s2_d [NumLanes];
  lbcm_s2_t  s2_q [NumLanes];
  lbcm_res_t res_d [NumLanes];
  lbcm_res_t res_q [NumLanes];

  logic                  req_dec;
  logic                  is_lit;
  logic [ValW-1:0]       in_val  [NumLanes];
  logic [CodeW-1:0]      in_code [NumLanes];
  logic [ExtraW-1:0]     in_ext  [NumLanes];

  // Unpack the input beat.
  assign req_dec                = s_axis_tuser[0];
  assign is_lit                 = s_axis_tuser[1];
  assign in_val[LaneDist]       = s_axis_tdata[31:0];
  assign in_val[LaneLen]        = s_axis_tdata[63:32];
  assign in_code[LaneDist]      = s_axis_tdata[71:64];
  assign in_code[LaneLen]       = s_axis_tdata[79:72];
  assign in_ext[LaneDist]       = s_axis_tdata[107:80];
  assign in_ext[LaneLen]        = s_axis_tdata[135:108];

  // Each stage moves when it is empty or the stage after it moves.
  assign adv[2]        = !vld_q[2] || m_axis_tready;
  assign adv[1]        = !vld_q[1] || adv[2];
  assign adv[0]        = !vld_q[0] || adv[1];
  assign s_axis_tready = adv[0];

  // Stage one: classify each lane, range check, offset or mask the value.
  always_comb begin
    logic [CodeW-1:0]  k;
    logic [BitsW:0]    w;
    logic [ExtraW-1:0] msk;
    for (int i = 0; i < NumLanes; i++) begin
      k = in_code[i] - RsvCodes;
      w = {1'b0, k[CodeW-1:SlotW]} + 6'd1;
      msk = ~({ExtraW{1'b1}} << w);
      s1_d[i].dec = req_dec;
      if (!req_dec) begin
        s1_d[i].act   = !is_lit;
        s1_d[i].rsv   = (in_val[i] < ValW'(RsvCodes));
        s1_d[i].err   = (in_val[i] > LastValue);
        s1_d[i].code  = in_val[i][CodeW-1:0];
        s1_d[i].val   = in_val[i] + ValW'(RsvCodes);
      end else begin
        s1_d[i].act   = (in_code[LaneDist] != '0);
        s1_d[i].rsv   = (in_code[i] < RsvCodes);
        s1_d[i].err   = (in_code[i] > LastCode);
        s1_d[i].code  = in_code[i];
        s1_d[i].val   = ValW'(in_ext[i] & msk);
      end
    end
  end

  // Stage two: group from the leading one (encode) or from the code (decode),
  // and the decode base ((8 + slot) << (group + 1)) - 8.
  always_comb begin
    logic [CodeW-1:0] k;
    logic [GrpW-1:0]  g;
    for (int i = 0; i < NumLanes; i++) begin
      k = s1_q[i].code - RsvCodes;
      g = s1_q[i].dec ? k[CodeW-1:SlotW] : (msb_pos(s1_q[i].val) - GrpW'(4));
      s2_d[i].dec   = s1_q[i].dec;
      s2_d[i].act   = s1_q[i].act;
      s2_d[i].rsv   = s1_q[i].rsv;
      s2_d[i].err   = s1_q[i].err;
      s2_d[i].code  = s1_q[i].code;
      s2_d[i].grp   = g;
      s2_d[i].val   = s1_q[i].val;
      s2_d[i].base  = ((ValW'(RsvCodes) + ValW'(k[SlotW-1:0])) << ({1'b0, g} + 6'd1))
                      - ValW'(RsvCodes);
    end
  end

  // Stage three: slot and extra for encode, base plus extra for decode.
  always_comb begin
    logic [BitsW:0]   w;
    logic [ValW-1:0]  sh;
    for (int i = 0; i < NumLanes; i++) begin
      w  = {1'b0, s2_q[i].grp} + 6'd1;
      sh = s2_q[i].val >> w;
      res_d[i] = '0;
      if (s2_q[i].act && !s2_q[i].err) begin
        if (!s2_q[i].dec) begin
          if (s2_q[i].rsv) begin
            res_d[i].code = s2_q[i].code;
          end else begin
            res_d[i].code  = RsvCodes + {s2_q[i].grp, sh[SlotW-1:0]};
            res_d[i].bits  = w[BitsW-1:0];
            res_d[i].extra = s2_q[i].val[ExtraW-1:0] & ~({ExtraW{1'b1}} << w);
          end
        end else begin
          if (s2_q[i].rsv) begin
            res_d[i].value = ValW'(s2_q[i].code);
          end else begin
            res_d[i].bits  = w[BitsW-1:0];
            res_d[i].value = s2_q[i].base + s2_q[i].val;
          end
        end
      end
      res_d[i].err = s2_q[i].act && s2_q[i].err;
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      if (adv[1]) begin
        vld_q[1] <= vld_q[0];
      end
      if (adv[2]) begin
        vld_q[2] <= vld_q[1];
      end
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv[0] && s_axis_tvalid) begin
      s1_q <= s1_d;
    end
    if (adv[1] && vld_q[0]) begin
      s2_q <= s2_d;
    end
    if (adv[2] && vld_q[1]) begin
      res_q <= res_d;
    end
  end

  // Pack the output beat.
  assign m_axis_tvalid = vld_q[2];
  assign m_axis_tdata  = {6'b0,
                          res_q[LaneLen].value,  res_q[LaneDist].value,
                          res_q[LaneLen].extra,  res_q[LaneDist].extra,
                          res_q[LaneLen].bits,   res_q[LaneDist].bits,
                          res_q[LaneLen].code,   res_q[LaneDist].code};
  assign m_axis_tuser  = res_q[LaneDist].err || res_q[LaneLen].err;

  // An empty output stage never holds back the input.
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[2] |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

  // An accepted beat always lands in stage one.
  a_beat_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted beat lost at stage one");

  // A grouped distance code carries the extra-bit count of its group.
  a_dist_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (res_q[LaneDist].code >= RsvCodes)) |->
      (res_q[LaneDist].bits ==
       BitsW'(((res_q[LaneDist].code - RsvCodes) >> SlotW) + 8'd1)))
    else $error("distance code and extra-bit count disagree");

  // Encoded length extra never exceeds its bucket width.
  a_len_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((res_q[LaneLen].extra >> res_q[LaneLen].bits) == '0))
    else $error("length extra wider than its bucket");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
  import lbcm_pkg::*;

  localparam int unsigned CodeSpace = 256;
  localparam int unsigned SlotsPerGroup = 8;
  localparam logic [63:0] ValueCeiling = 64'hFFFF_FFFF;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned DrainCycles = 10;

  // Request kinds carried in the low tuser bit.
  localparam logic ReqEncode = 1'b0;
  localparam logic ReqDecode = 1'b1;

  // One input beat, tuser above tdata; the last member sits in the lowest bits.
  typedef struct packed {
    logic              is_literal;
    logic              req_type;
    logic [ExtraW-1:0] len_extra_in;
    logic [ExtraW-1:0] dist_extra_in;
    logic [CodeW-1:0]  len_code_in;
    logic [CodeW-1:0]  dist_code_in;
    logic [ValW-1:0]   length;
    logic [ValW-1:0]   distance;
  } token_t;

  // One output beat, error above tdata.
  typedef struct packed {
    logic              err;
    logic [5:0]        pad;
    logic [ValW-1:0]   length_out;
    logic [ValW-1:0]   distance_out;
    logic [ExtraW-1:0] len_extra;
    logic [ExtraW-1:0] dist_extra;
    logic [BitsW-1:0]  len_bits;
    logic [BitsW-1:0]  dist_bits;
    logic [CodeW-1:0]  len_code;
    logic [CodeW-1:0]  dist_code;
  } bucket_map_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic [InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;

  bucket_map_t expected_maps[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  log_bucket_code_mapper u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run limit reached with %0d results pending", $time, expected_maps.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Walks the buckets in order until the key (a value or a code) is found.
  function automatic bit bucket_lookup(input bit by_code, input logic [63:0] key,
                                       output logic [CodeW-1:0] code,
                                       output logic [BitsW-1:0] nbits,
                                       output logic [ValW-1:0] base);
    logic [63:0] c, v, w, slot, span, top;
    code = '0;
    nbits = '0;
    base = '0;
    if (key < RsvCodes) begin
      code = key[CodeW-1:0];
      base = key[ValW-1:0];
      return 1'b1;
    end
    c = 64'(RsvCodes);
    v = 64'(RsvCodes);
    w = 64'd1;
    slot = 64'd0;
    while (c < CodeSpace) begin
      span = 64'd1 << w;
      top = v + span - 1;
      if (top >= ValueCeiling) break;
      if (by_code ? (c == key) : (key >= v && key <= top)) begin
        code = c[CodeW-1:0];
        nbits = w[BitsW-1:0];
        base = v[ValW-1:0];
        return 1'b1;
      end
      c++;
      slot++;
      v += span;
      if (slot >= SlotsPerGroup) begin
        slot = 64'd0;
        w++;
      end
    end
    return 1'b0;
  endfunction

  // Expected output beat for one token.
  function automatic bucket_map_t map_token(input token_t tok);
    bucket_map_t m;
    logic [CodeW-1:0] code;
    logic [BitsW-1:0] nbits;
    logic [ValW-1:0] base;
    logic [63:0] mask;
    m = '0;
    if (tok.req_type == ReqEncode) begin
      if (!tok.is_literal) begin
        if (bucket_lookup(1'b0, {32'd0, tok.distance}, code, nbits, base)) begin
          m.dist_code = code;
          m.dist_bits = nbits;
          m.dist_extra = ExtraW'(tok.distance - base);
        end else begin
          m.err = 1'b1;
        end
        if (bucket_lookup(1'b0, {32'd0, tok.length}, code, nbits, base)) begin
          m.len_code = code;
          m.len_bits = nbits;
          m.len_extra = ExtraW'(tok.length - base);
        end else begin
          m.err = 1'b1;
        end
      end
    end else if (tok.dist_code_in != '0) begin
      // A zero distance code marks a literal: nothing is decoded.
      if (bucket_lookup(1'b1, {56'd0, tok.dist_code_in}, code, nbits, base)) begin
        mask = (64'd1 << nbits) - 1;
        m.dist_bits = nbits;
        m.distance_out = ValW'(base + (tok.dist_extra_in & mask));
      end else begin
        m.err = 1'b1;
      end
      if (bucket_lookup(1'b1, {56'd0, tok.len_code_in}, code, nbits, base)) begin
        mask = (64'd1 << nbits) - 1;
        m.len_bits = nbits;
        m.length_out = ValW'(base + (tok.len_extra_in & mask));
      end else begin
        m.err = 1'b1;
      end
    end
    return m;
  endfunction

  function automatic token_t encode_token(input logic lit, input logic [ValW-1:0] d,
                                          input logic [ValW-1:0] l);
    token_t t;
    t = '0;
    t.req_type = ReqEncode;
    t.is_literal = lit;
    t.distance = d;
    t.length = l;
    return t;
  endfunction

  function automatic token_t decode_token(input logic [CodeW-1:0] dc, input logic [CodeW-1:0] lc,
                                          input logic [ExtraW-1:0] dx,
                                          input logic [ExtraW-1:0] lx);
    token_t t;
    t = '0;
    t.req_type = ReqDecode;
    t.dist_code_in = dc;
    t.len_code_in = lc;
    t.dist_extra_in = dx;
    t.len_extra_in = lx;
    return t;
  endfunction

  // Values spread over all magnitudes, with extra weight near both ends.
  function automatic logic [ValW-1:0] random_value();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom >> $urandom_range(31);
      2: return 32'hFFFF_FFFF - $urandom_range(40);
      default: return $urandom_range(40);
    endcase
  endfunction

  // Mostly valid codes, some literals and some beyond the last bucket.
  function automatic logic [CodeW-1:0] random_code();
    case ($urandom_range(15))
      0: return '0;
      1, 2: return CodeW'($urandom_range(255, LastCode + 1));
      default: return CodeW'($urandom_range(LastCode, 1));
    endcase
  endfunction

  function automatic token_t random_token();
    token_t t;
    t.req_type = 1'($urandom_range(1));
    t.is_literal = ($urandom_range(9) == 0);
    t.distance = random_value();
    t.length = random_value();
    t.dist_code_in = random_code();
    t.len_code_in = random_code();
    t.dist_extra_in = ExtraW'($urandom);
    t.len_extra_in = ExtraW'($urandom);
    return t;
  endfunction

  // Offers one beat, idling first at random, and records its expected result once accepted.
  task automatic send_token(input token_t tok);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    {s_axis_tuser, s_axis_tdata} <= tok;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_maps = {expected_maps, map_token(tok)};
  endtask

  // Output side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Compares each output beat with the oldest expected result.
  always @(posedge clk_i) begin
    bucket_map_t exp_m;
    bucket_map_t act_m;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_m = {m_axis_tuser, m_axis_tdata};
      if (expected_maps.size() == 0) begin
        $display("%0t: unexpected beat: expected none, actual 0x%0h", $time, act_m);
        mismatches++;
      end else begin
        exp_m = expected_maps.pop_front();
        check_field("dist_code", 32'(exp_m.dist_code), 32'(act_m.dist_code));
        check_field("len_code", 32'(exp_m.len_code), 32'(act_m.len_code));
        check_field("dist_extra_bits", 32'(exp_m.dist_bits), 32'(act_m.dist_bits));
        check_field("len_extra_bits", 32'(exp_m.len_bits), 32'(act_m.len_bits));
        check_field("dist_extra", 32'(exp_m.dist_extra), 32'(act_m.dist_extra));
        check_field("len_extra", 32'(exp_m.len_extra), 32'(act_m.len_extra));
        check_field("distance_out", exp_m.distance_out, act_m.distance_out);
        check_field("length_out", exp_m.length_out, act_m.length_out);
        check_field("error", 32'(exp_m.err), 32'(act_m.err));
      end
    end
  end

  // Encode corners: reserved values, group edges, the last bucket and beyond, literals.
  task automatic test_encode_edges();
    send_token(encode_token(1'b0, 32'd0, 32'd7));
    send_token(encode_token(1'b0, 32'd8, 32'd9));
    send_token(encode_token(1'b0, 32'd23, 32'd24));
    send_token(encode_token(1'b0, 32'd27, 32'd87));
    send_token(encode_token(1'b0, 32'hFFFF_FFF7, 32'hFFFF_FFF0));
    send_token(encode_token(1'b0, 32'hFFFF_FFF8, 32'd100));
    send_token(encode_token(1'b0, 32'd100, 32'hFFFF_FFFF));
    send_token(encode_token(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFF8));
    send_token(encode_token(1'b1, 32'hFFFF_FFFF, 32'd12345));
    send_token(encode_token(1'b0, 32'h8000_0000, 32'h0FFF_FFFF));
  endtask

  // Decode corners: literal code, reserved codes with masked extra, first and last bucket,
  // codes beyond the last bucket on either side.
  task automatic test_decode_edges();
    send_token(decode_token(8'd0, 8'd255, 28'hFFF_FFFF, 28'hFFF_FFFF));
    send_token(decode_token(8'd1, 8'd7, 28'hFFF_FFFF, 28'hFFF_FFFF));
    send_token(decode_token(8'd8, 8'd15, 28'hFFF_FFFF, 28'd0));
    send_token(decode_token(8'd16, 8'd0, 28'd5, 28'hFFF_FFFF));
    send_token(decode_token(LastCode, LastCode, 28'hFFF_FFFF, 28'h800_0000));
    send_token(decode_token(LastCode + 8'd1, 8'd100, 28'd3, 28'd3));
    send_token(decode_token(8'd100, 8'd255, 28'h123_4567, 28'd1));
    send_token(decode_token(8'd255, 8'd232, 28'd0, 28'd0));
    send_token(decode_token(8'd230, 8'd223, 28'h7FF_FFFF, 28'hABC_DEF0));
  endtask

  task automatic test_random_tokens(input int unsigned count, input int unsigned idle_pct,
                                    input int unsigned stall_pct);
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (count) send_token(random_token());
  endtask

  // Output held off for a long stretch while beats keep coming, so the pipeline fills.
  task automatic test_output_holdoff();
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_reqs++;
    repeat (40) send_token(random_token());
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_encode_edges();
    test_decode_edges();
    test_random_tokens(200, 0, 0);
    test_random_tokens(200, 76, 0);
    test_random_tokens(200, 0, 76);
    test_random_tokens(200, 22, 22);
    test_output_holdoff();
    s_axis_tvalid <= 1'b0;

    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/lbcm_pkg.sv
rtl/core/log_bucket_code_mapper.sv
sim/tb.sv
